// ===== sv/spq_pkg.sv =====
package spq_pkg;

    // Default depth of the cell row.
    localparam int DEFAULT_CAPACITY = 16;

    // Fixed widths of the command and result words.
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    // Operation codes carried by a command word.
    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_EXTRACT = 2'd1,
        KIND_PEEK    = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    // Status codes carried by a result word.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command word.
    typedef struct packed {
        kind_t                     kind;
        logic signed [DATA_W-1:0]  item_value;
        logic signed [DATA_W-1:0]  item_priority;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic signed [DATA_W-1:0]  out_value;
        status_t                   status;
        logic [COUNT_W-1:0]        entry_count;
        logic                      queue_empty;
    } out_word_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic                      insert;
        logic                      extract;
        logic signed [DATA_W-1:0]  new_value;
        logic signed [DATA_W-1:0]  new_priority;
    } cell_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell (
    input  logic                               clk,
    input  spq_pkg::cell_ctrl_t                ctrl,
    input  logic                               occupied,
    input  logic                               left_ge,
    input  logic signed [spq_pkg::DATA_W-1:0]  left_value,
    input  logic signed [spq_pkg::DATA_W-1:0]  left_priority,
    input  logic signed [spq_pkg::DATA_W-1:0]  right_value,
    input  logic signed [spq_pkg::DATA_W-1:0]  right_priority,
    output logic                               ge,
    output logic signed [spq_pkg::DATA_W-1:0]  value,
    output logic signed [spq_pkg::DATA_W-1:0]  pri
);

    logic signed [spq_pkg::DATA_W-1:0] value_reg, value_next;
    logic signed [spq_pkg::DATA_W-1:0] priority_reg, priority_next;

    // A held entry whose priority is at least the new one stays ahead of it.
    assign ge = occupied && (priority_reg >= ctrl.new_priority);

    // Keep, take the new word, shift in from the left, or pull in from the right.
    always_comb
    begin
        value_next    = value_reg;
        priority_next = priority_reg;
        if (ctrl.insert && !ge)
        begin
            if (left_ge)
            begin
                value_next    = ctrl.new_value;
                priority_next = ctrl.new_priority;
            end
            else
            begin
                value_next    = left_value;
                priority_next = left_priority;
            end
        end
        else if (ctrl.extract)
        begin
            value_next    = right_value;
            priority_next = right_priority;
        end
    end

    // Entry storage carries no reset; the fill count says which cells hold data.
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

    assign value = value_reg;
    assign pri   = priority_reg;

endmodule

// ===== sv/stable_sorted_priority_queue_unit.sv =====
// The result word is registered and appears in the cycle after the command
// word is taken. The block takes one command word per cycle; the whole cell
// row updates together, each cell comparing against the broadcast priority
// and shifting. busy stays low; the receiver cannot stall the result strobe.
// Reset clears the fill count and the strobe; cell contents are not reset.
module stable_sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  spq_pkg::in_word_t  cmd,
    output logic               done,
    output spq_pkg::out_word_t result
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]           count_reg, count_next;
    logic                    done_reg;
    spq_pkg::out_word_t      result_reg, result_next;
    spq_pkg::cell_ctrl_t     ctrl;
    logic                    accept;
    logic                    full;
    logic                    empty;

    logic                               cell_ge    [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0]  cell_value [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0]  cell_pri   [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);

    // Decode the command word into cell control, next count and result word.
    always_comb
    begin
        ctrl.insert       = 1'b0;
        ctrl.extract      = 1'b0;
        ctrl.new_value    = cmd.item_value;
        ctrl.new_priority = cmd.item_priority;
        count_next        = count_reg;
        result_next.out_value = '0;
        result_next.status    = spq_pkg::ST_OK;
        unique case (cmd.kind)
            spq_pkg::KIND_INSERT:
            begin
                if (full)
                begin
                    result_next.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.insert = accept;
                    count_next  = count_reg + CW'(1);
                end
            end
            spq_pkg::KIND_EXTRACT:
            begin
                if (empty)
                begin
                    result_next.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.extract          = accept;
                    count_next            = count_reg - CW'(1);
                    result_next.out_value = cell_value[0];
                end
            end
            spq_pkg::KIND_PEEK:
            begin
                if (empty)
                begin
                    result_next.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    result_next.out_value = cell_value[0];
                end
            end
            spq_pkg::KIND_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        result_next.entry_count = spq_pkg::COUNT_W'(count_next);
        result_next.queue_empty = (count_next == '0);
    end

    // The row of compare-and-shift cells, head at cell zero.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                               left_ge;
        logic signed [spq_pkg::DATA_W-1:0]  left_value;
        logic signed [spq_pkg::DATA_W-1:0]  left_pri;
        logic signed [spq_pkg::DATA_W-1:0]  right_value;
        logic signed [spq_pkg::DATA_W-1:0]  right_pri;

        if (i == 0)
        begin : g_head
            assign left_ge    = 1'b1;
            assign left_value = cell_value[i];
            assign left_pri   = cell_pri[i];
        end
        else
        begin : g_body
            assign left_ge    = cell_ge[i-1];
            assign left_value = cell_value[i-1];
            assign left_pri   = cell_pri[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = cell_value[i];
            assign right_pri   = cell_pri[i];
        end
        else
        begin : g_next
            assign right_value = cell_value[i+1];
            assign right_pri   = cell_pri[i+1];
        end

        spq_cell u_cell (
            .clk            (clk),
            .ctrl           (ctrl),
            .occupied       (CW'(i) < count_reg),
            .left_ge        (left_ge),
            .left_value     (left_value),
            .left_priority  (left_pri),
            .right_value    (right_value),
            .right_priority (right_pri),
            .ge             (cell_ge[i]),
            .value          (cell_value[i]),
            .pri            (cell_pri[i])
        );
    end

    // Fill count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import spq_pkg::*;

    localparam int DEPTH = DEFAULT_CAPACITY;
    localparam int RANDOM_WORDS = 950;
    localparam int BURST_LEN = 25;

    localparam logic signed [DATA_W-1:0] MAX_S = 32'h7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_S = 32'h8000_0000;

    // One line of the directed plan: a command word, how many times to send it
    // (the value steps by one each time), and an optional hand-written result.
    typedef struct {
        in_word_t  word;
        int        reps;
        bit        pinned;
        out_word_t pin;
    } plan_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  cmd;
    logic      done;
    out_word_t result;

    // Hand-written result that rides along with the command word.
    logic      pin_en;
    out_word_t pin_word;

    // Mirror of the sorted store, head at index 0.
    logic signed [DATA_W-1:0] mirror_value [DEPTH];
    logic signed [DATA_W-1:0] mirror_priority [DEPTH];
    int                       mirror_count;

    out_word_t reports_due [$];
    int        mismatches;

    stable_sorted_priority_queue_unit #(
        .CAPACITY(DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Apply one command to the mirror and return the result word it owes.
    function automatic out_word_t sorted_queue_step(in_word_t w);
        out_word_t r;
        int        pos;
        int        i;
        r = '0;
        r.status = ST_OK;
        case (w.kind)
            KIND_INSERT:
            begin
                if (mirror_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // A new entry goes behind every entry of equal or higher priority.
                    pos = 0;
                    while (pos < mirror_count && mirror_priority[pos] >= w.item_priority)
                    begin
                        pos++;
                    end
                    for (i = mirror_count; i > pos; i--)
                    begin
                        mirror_value[i] = mirror_value[i-1];
                        mirror_priority[i] = mirror_priority[i-1];
                    end
                    mirror_value[pos] = w.item_value;
                    mirror_priority[pos] = w.item_priority;
                    mirror_count++;
                end
            end
            KIND_EXTRACT:
            begin
                if (mirror_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.out_value = mirror_value[0];
                    for (i = 1; i < mirror_count; i++)
                    begin
                        mirror_value[i-1] = mirror_value[i];
                        mirror_priority[i-1] = mirror_priority[i];
                    end
                    mirror_count--;
                end
            end
            KIND_PEEK:
            begin
                if (mirror_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.out_value = mirror_value[0];
                end
            end
            default:
            begin
                mirror_count = 0;
            end
        endcase
        r.entry_count = mirror_count[COUNT_W-1:0];
        r.queue_empty = (mirror_count == 0);
        return r;
    endfunction

    function automatic plan_row_t plan_row(kind_t k, logic signed [DATA_W-1:0] v,
                                           logic signed [DATA_W-1:0] p, int reps,
                                           bit pinned, logic signed [DATA_W-1:0] pv,
                                           status_t ps, int pc, bit pe);
        plan_row_t row;
        row.word.kind = k;
        row.word.item_value = v;
        row.word.item_priority = p;
        row.reps = reps;
        row.pinned = pinned;
        row.pin.out_value = pv;
        row.pin.status = ps;
        row.pin.entry_count = pc[COUNT_W-1:0];
        row.pin.queue_empty = pe;
        return row;
    endfunction

    task automatic report_field(string what, longint want, longint got);
        mismatches++;
        if (mismatches <= 30)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Check each result word against the oldest one owed, then record what a
    // word accepted at this edge will owe.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (reports_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 30)
                    begin
                        $display("%0t: result word with none owed, actual %h", $time, result);
                    end
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (result.out_value !== want.out_value)
                    begin
                        report_field("out_value", want.out_value, result.out_value);
                    end
                    if (result.status !== want.status)
                    begin
                        report_field("status", want.status, result.status);
                    end
                    if (result.entry_count !== want.entry_count)
                    begin
                        report_field("entry_count", want.entry_count, result.entry_count);
                    end
                    if (result.queue_empty !== want.queue_empty)
                    begin
                        report_field("queue_empty", want.queue_empty, result.queue_empty);
                    end
                end
            end
            if (start && !busy)
            begin
                want = sorted_queue_step(cmd);
                reports_due.push_back(pin_en ? pin_word : want);
            end
        end
    end

    // Present one command word and hold it until the block takes it.
    task automatic send_word(in_word_t w, bit pinned, out_word_t pin);
        cmd <= w;
        pin_en <= pinned;
        pin_word <= pin;
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    initial
    begin
        plan_row_t directed_plan [];
        in_word_t  w;
        int        n;
        int        r;
        int        mode;
        int        idle_pct;
        int        tail;
        int        sent;
        int        burst;

        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= '0;
        pin_en <= 1'b0;
        pin_word <= '0;
        mirror_count = 0;
        mismatches = 0;

        directed_plan = '{
            plan_row(KIND_PEEK,    0,     0,     1, 1, 0,     ST_EMPTY, 0, 1),
            plan_row(KIND_EXTRACT, -1,    -1,    1, 1, 0,     ST_EMPTY, 0, 1),
            plan_row(KIND_CLEAR,   0,     0,     1, 1, 0,     ST_OK,    0, 1),
            plan_row(KIND_INSERT,  MAX_S, MIN_S, 1, 1, 0,     ST_OK,    1, 0),
            plan_row(KIND_INSERT,  MIN_S, MAX_S, 1, 1, 0,     ST_OK,    2, 0),
            plan_row(KIND_PEEK,    0,     0,     1, 1, MIN_S, ST_OK,    2, 0),
            plan_row(KIND_INSERT,  1,     MAX_S, 1, 1, 0,     ST_OK,    3, 0),
            plan_row(KIND_INSERT,  2,     MIN_S, 1, 1, 0,     ST_OK,    4, 0),
            plan_row(KIND_EXTRACT, 0,     0,     1, 1, MIN_S, ST_OK,    3, 0),
            plan_row(KIND_EXTRACT, 0,     0,     1, 1, 1,     ST_OK,    2, 0),
            plan_row(KIND_EXTRACT, 0,     0,     1, 1, MAX_S, ST_OK,    1, 0),
            plan_row(KIND_EXTRACT, 0,     0,     1, 1, 2,     ST_OK,    0, 1),
            plan_row(KIND_INSERT,  -1,    0,     1, 0, 0,     ST_OK,    0, 0),
            plan_row(KIND_INSERT,  5,     -1,    1, 0, 0,     ST_OK,    0, 0),
            plan_row(KIND_INSERT,  6,     1,     1, 0, 0,     ST_OK,    0, 0),
            plan_row(KIND_PEEK,    MAX_S, MAX_S, 1, 0, 0,     ST_OK,    0, 0),
            plan_row(KIND_INSERT,  0,     0,     1, 0, 0,     ST_OK,    0, 0),
            plan_row(KIND_CLEAR,   MIN_S, MIN_S, 1, 1, 0,     ST_OK,    0, 1),
            plan_row(KIND_INSERT,  100,   3,     DEPTH, 0, 0, ST_OK,    0, 0),
            plan_row(KIND_INSERT,  MAX_S, MAX_S, 1, 1, 0,     ST_FULL,  DEPTH, 0),
            plan_row(KIND_PEEK,    0,     0,     1, 0, 0,     ST_OK,    0, 0),
            plan_row(KIND_EXTRACT, 0,     0,     1, 0, 0,     ST_OK,    0, 0),
            plan_row(KIND_INSERT,  -7,    MAX_S, 1, 0, 0,     ST_OK,    0, 0),
            plan_row(KIND_EXTRACT, 0,     0,     1, 0, 0,     ST_OK,    0, 0),
            plan_row(KIND_CLEAR,   0,     0,     1, 1, 0,     ST_OK,    0, 1)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words, back to back; repeated rows step the value by one.
        foreach (directed_plan[i])
        begin
            for (n = 0; n < directed_plan[i].reps; n++)
            begin
                w = directed_plan[i].word;
                w.item_value = w.item_value + n;
                send_word(w, directed_plan[i].pinned, directed_plan[i].pin);
            end
        end

        // Random bursts, each leaning toward filling, draining or neither, so
        // the store keeps swinging between empty and full. The sender's idle
        // rate changes every eight bursts.
        sent = 0;
        burst = 0;
        while (sent < RANDOM_WORDS)
        begin
            mode = $urandom_range(0, 2);
            case ((burst / 8) % 3)
                0: idle_pct = 0;
                1: idle_pct = 56;
                default: idle_pct = 15;
            endcase
            for (n = 0; n < BURST_LEN; n++)
            begin
                r = $urandom_range(0, 99);
                if (r >= 98)
                begin
                    w.kind = KIND_CLEAR;
                end
                else if (r < (mode == 0 ? 70 : (mode == 1 ? 30 : 45)))
                begin
                    w.kind = KIND_INSERT;
                end
                else if (r < (mode == 0 ? 85 : (mode == 1 ? 80 : 75)))
                begin
                    w.kind = KIND_EXTRACT;
                end
                else
                begin
                    w.kind = KIND_PEEK;
                end

                r = $urandom_range(0, 9);
                w.item_value = (r == 0) ? MAX_S : ((r == 1) ? MIN_S : $urandom);

                // Mostly a narrow band of priorities, so ties are common.
                r = $urandom_range(0, 9);
                if (r < 6)
                begin
                    w.item_priority = int'($urandom_range(0, 6)) - 3;
                end
                else if (r < 8)
                begin
                    w.item_priority = $urandom;
                end
                else
                begin
                    w.item_priority = (r == 8) ? MAX_S : MIN_S;
                end

                send_word(w, 1'b0, '0);
                sent++;
                if (int'($urandom_range(0, 99)) < idle_pct)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
            end
            burst++;
        end
        start <= 1'b0;

        // Drain the words still owed.
        tail = 0;
        while (reports_due.size() != 0 && tail < 50)
        begin
            @(posedge clk);
            tail++;
        end
        repeat (3) @(posedge clk);

        if (mismatches == 0 && reports_due.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
